// ===== rtl/accel_motion_detector_defines.svh =====
// assertion macros shared by the motion detector rtl
`ifndef ACCEL_MOTION_DETECTOR_DEFINES_SVH
`define ACCEL_MOTION_DETECTOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define AMD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define AMD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/amd_pkg.sv =====
// shared types, constants and register map of the motion detector
package amd_pkg;

   localparam int AMD_AXIS_BITS = 16;
   localparam int AMD_FRAC_BITS = 4;

   localparam int AXIS_W      = 16;
   localparam int MAG_W       = 20;
   localparam int CNT_W       = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [MAG_W-1:0] THRESHOLD_RESET   = MAG_W'(1600);
   localparam logic [CNT_W-1:0] STOP_COUNT_RESET  = CNT_W'(10);
   localparam logic [CNT_W-1:0] START_COUNT_RESET = CNT_W'(5);

   typedef enum logic [1:0] {
      REG_MOTION_THRESH = 2'd0,
      REG_STOP_COUNT    = 2'd1,
      REG_START_COUNT   = 2'd2
   } amd_reg_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] accel_x;
      logic signed [AXIS_W-1:0] accel_y;
      logic signed [AXIS_W-1:0] accel_z;
   } amd_req_type;

   typedef struct packed {
      logic             sample_valid;
      logic             is_moving;
      logic [MAG_W-1:0] magnitude;
      logic [MAG_W-1:0] magnitude_change;
   } amd_rsp_type;

   typedef struct packed {
      logic [MAG_W-1:0] motion_thresh;
      logic [CNT_W-1:0] stop_count;
      logic [CNT_W-1:0] start_count;
   } amd_cfg_type;

endpackage

// ===== rtl/accel_motion_detector.sv =====
// top level of the accelerometer motion detector.
// Each request carries one x/y/z sample; each produces exactly one response with the
// magnitude sqrt(x^2+y^2+z^2) in fixed point with FRAC_BITS fraction bits, its absolute
// change from the last good sample, and a debounced moving flag. A sample with any axis
// reading all ones is answered with sample_valid low, zero magnitude fields and the
// current flag, and leaves all state alone. The front end registers the squares of the axes
// and sums them, and hands the sum through a two-entry queue to the back end, whose
// bit-serial square root produces one result bit per cycle. A good sample occupies the
// back end from its queue pop through one root step per result bit to the finish state,
// which waits for a free response register; a bad sample goes from the pop straight to the
// finish state. The back end works on one sample at a time, while the queue holds the
// next ones. The response register lets the back end start the next root while a
// response is stalled.
`include "accel_motion_detector_defines.svh"

module accel_motion_detector
   import amd_pkg::*;
#(
   parameter int AXIS_BITS = AMD_AXIS_BITS,
   parameter int FRAC_BITS = AMD_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  amd_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output amd_rsp_type           rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int JOB_W = 2 * AXIS_BITS + 1;

   amd_cfg_type      cfg;
   logic             q_push, q_pop, q_full, q_empty;
   logic [JOB_W-1:0] q_push_job, q_pop_job;
   logic             rsp_bad, rsp_zero;

   amd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   amd_front #(
      .AXIS_BITS (AXIS_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (q_push_job)
   );

   amd_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_job),
      .pop       (q_pop),
      .pop_data  (q_pop_job),
      .full      (q_full),
      .empty     (q_empty)
   );

   amd_back #(
      .AXIS_BITS (AXIS_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .q_job     (q_pop_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_bad  = rsp_valid & ~rsp_data.sample_valid;
   assign rsp_zero = (rsp_data.magnitude == '0) & (rsp_data.magnitude_change == '0);

   `AMD_ASSERT_SAME(a_no_push_full, q_push, !q_full, "push into a full queue")
   `AMD_ASSERT_SAME(a_no_pop_empty, q_pop, !q_empty, "pop from an empty queue")
   `AMD_ASSERT_SAME(a_bad_sample_zero, rsp_bad, rsp_zero, "bad sample with nonzero magnitude")
   `AMD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")

endmodule

// ===== rtl/amd_csr.sv =====
// configuration registers behind the apb-style port
module amd_csr
   import amd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output amd_cfg_type           cfg
);

   amd_cfg_type cfg_ff, cfg_in;
   logic [1:0]  reg_index;
   logic        wr_en;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_MOTION_THRESH: cfg_in.motion_thresh = csr_pwdata[MAG_W-1:0];
            REG_STOP_COUNT:    cfg_in.stop_count = csr_pwdata[CNT_W-1:0];
            REG_START_COUNT:   cfg_in.start_count = csr_pwdata[CNT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_MOTION_THRESH: csr_prdata = CSR_DATA_W'(cfg_ff.motion_thresh);
         REG_STOP_COUNT:    csr_prdata = CSR_DATA_W'(cfg_ff.stop_count);
         REG_START_COUNT:   csr_prdata = CSR_DATA_W'(cfg_ff.start_count);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motion_thresh <= THRESHOLD_RESET;
         cfg_ff.stop_count    <= STOP_COUNT_RESET;
         cfg_ff.start_count   <= START_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/amd_front.sv =====
// front end: takes a request, flags a minus-one axis and forms the sum of squares
module amd_front
   import amd_pkg::*;
#(
   parameter int AXIS_BITS = AMD_AXIS_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  amd_req_type            req_data,
   input  logic                   q_full,
   output logic                   q_push,
   output logic [2*AXIS_BITS:0]   q_job
);

   localparam int SUM_W = 2 * AXIS_BITS;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_invalid_ff;
   logic [SUM_W-1:0]        sq_x_ff, sq_y_ff, sq_z_ff;
   logic signed [AXIS_BITS-1:0] ax, ay, az;
   logic signed [SUM_W-1:0] px, py, pz;
   logic                    minus_one;
   logic                    accept;
   logic [SUM_W-1:0]        sum;

   assign ax = req_data.accel_x[AXIS_BITS-1:0];
   assign ay = req_data.accel_y[AXIS_BITS-1:0];
   assign az = req_data.accel_z[AXIS_BITS-1:0];
   assign px = ax * ax;
   assign py = ay * ay;
   assign pz = az * az;

   // an all-ones axis marks a failed read
   assign minus_one = (req_data.accel_x[AXIS_BITS-1:0] == '1) |
                      (req_data.accel_y[AXIS_BITS-1:0] == '1) |
                      (req_data.accel_z[AXIS_BITS-1:0] == '1);

   assign req_stall = s1_valid_ff & q_full;
   assign accept    = req_valid & ~req_stall;
   assign q_push    = s1_valid_ff & ~q_full;

   // three squares of at most 2^(2n-2) each never carry out of 2n bits
   assign sum   = sq_x_ff + sq_y_ff + sq_z_ff;
   assign q_job = {s1_invalid_ff, sum};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_invalid_ff <= minus_one;
         sq_x_ff       <= $unsigned(px);
         sq_y_ff       <= $unsigned(py);
         sq_z_ff       <= $unsigned(pz);
      end
   end

endmodule

// ===== rtl/amd_queue.sv =====
// short fifo between the front end and the square root engine
module amd_queue
   import amd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH,
   parameter int WIDTH = 2 * AMD_AXIS_BITS + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_QW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push & ~pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (pop & ~push) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/amd_back.sv =====
// back end: bit-serial square root, change detection, debounce and response register
module amd_back
   import amd_pkg::*;
#(
   parameter int AXIS_BITS = AMD_AXIS_BITS,
   parameter int FRAC_BITS = AMD_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  amd_cfg_type          cfg,
   input  logic                 q_empty,
   input  logic [2*AXIS_BITS:0] q_job,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output amd_rsp_type          rsp_data
);

   localparam int SUM_W  = 2 * AXIS_BITS;
   localparam int ROOT_W = AXIS_BITS + FRAC_BITS;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int ITER_W = $clog2(ROOT_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROOT,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic              invalid_ff, invalid_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [MAG_W-1:0]  last_mag_ff, last_mag_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              flag_ff, flag_in;
   logic              rsp_valid_ff, rsp_valid_in;
   amd_rsp_type       rsp_ff, rsp_in;

   logic              job_invalid;
   logic [SUM_W-1:0]  job_sum;
   logic [REM_W-1:0]  rem_shift, trial;
   logic              ge;
   logic [MAG_W-1:0]  mag, change;
   logic              below;
   logic [CNT_W-1:0]  cnt_inc;
   logic              out_free;

   assign job_invalid = q_job[SUM_W];
   assign job_sum     = q_job[SUM_W-1:0];

   // one result bit per cycle: bring down two radicand bits, try 4r+1
   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign ge        = (rem_shift >= trial);

   generate
      if (ROOT_W > MAG_W) begin : g_sat
         assign mag = (|root_ff[ROOT_W-1:MAG_W]) ? '1 : root_ff[MAG_W-1:0];
      end else begin : g_nosat
         assign mag = MAG_W'(root_ff);
      end
   endgenerate

   assign change   = (mag >= last_mag_ff) ? (mag - last_mag_ff) : (last_mag_ff - mag);
   assign below    = (change < cfg.motion_thresh);
   assign cnt_inc  = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + CNT_W'(1);
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      invalid_in   = invalid_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      iter_in      = iter_ff;
      last_mag_in  = last_mag_ff;
      cnt_in       = cnt_ff;
      flag_in      = flag_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      q_pop        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop      = 1'b1;
               invalid_in = job_invalid;
               rad_in     = RAD_W'(job_sum) << (2 * FRAC_BITS);
               rem_in     = '0;
               root_in    = '0;
               iter_in    = '0;
               state_in   = job_invalid ? ST_FINISH : ST_ROOT;
            end
         end
         ST_ROOT: begin
            rem_in  = ge ? (rem_shift - trial) : rem_shift;
            root_in = {root_ff[ROOT_W-2:0], ge};
            rad_in  = rad_ff << 2;
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(ROOT_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (invalid_ff) begin
                  rsp_in.sample_valid     = 1'b0;
                  rsp_in.is_moving        = flag_ff;
                  rsp_in.magnitude        = '0;
                  rsp_in.magnitude_change = '0;
               end else begin
                  last_mag_in = mag;
                  // a drop leaves the count at zero, a rise leaves it at one
                  if (flag_ff) begin
                     if (below) begin
                        if (cnt_ff > cfg.stop_count) begin
                           flag_in = 1'b0;
                           cnt_in  = '0;
                        end else begin
                           cnt_in = cnt_inc;
                        end
                     end else begin
                        cnt_in = '0;
                     end
                  end else begin
                     if (!below) begin
                        if (cnt_ff > cfg.start_count) begin
                           flag_in = 1'b1;
                           cnt_in  = CNT_W'(1);
                        end else begin
                           cnt_in = cnt_inc;
                        end
                     end else begin
                        cnt_in = '0;
                     end
                  end
                  rsp_in.sample_valid     = 1'b1;
                  rsp_in.is_moving        = flag_in;
                  rsp_in.magnitude        = mag;
                  rsp_in.magnitude_change = change;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         invalid_ff   <= 1'b0;
         rad_ff       <= '0;
         rem_ff       <= '0;
         root_ff      <= '0;
         iter_ff      <= '0;
         last_mag_ff  <= '0;
         cnt_ff       <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         invalid_ff   <= invalid_in;
         rad_ff       <= rad_in;
         rem_ff       <= rem_in;
         root_ff      <= root_in;
         iter_ff      <= iter_in;
         last_mag_ff  <= last_mag_in;
         cnt_ff       <= cnt_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

endmodule
